>>> design/sct_pkg.sv
`default_nettype none
package sct_pkg;

  localparam int ANGLE_FRAC_BITS  = 24;
  localparam int RESULT_FRAC_BITS = 30;
  localparam int WFRAC            = 30;

  // angle accumulator width: input range plus pi/2 plus the largest reduction step
  localparam int XW = 35;
  // polynomial operand and product widths
  localparam int UW  = 32;
  localparam int X2W = 34;
  localparam int PVW = 33;
  localparam int AW  = 35;
  localparam int BW  = 33;
  localparam int PW  = AW + BW;
  localparam int RW  = PW - WFRAC;

  // binary reduction: 2^RED_STEPS multiples of 2*pi cover the whole input range
  localparam int RED_STEPS = 30 - ANGLE_FRAC_BITS;
  localparam int STEP_W    = $clog2(RED_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RED_STEPS - 1);

  localparam int U_SHIFT   = WFRAC - ANGLE_FRAC_BITS;
  localparam int OUT_SHIFT = WFRAC - RESULT_FRAC_BITS;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_A =
    (PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
  localparam logic [63:0] HALF_PI_A =
    (PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
  localparam logic [63:0] TWO_PI_A =
    (PI_Q60 + (64'd1 << (58 - ANGLE_FRAC_BITS))) >> (59 - ANGLE_FRAC_BITS);

  localparam logic signed [XW-1:0] PI_X      = PI_A[XW-1:0];
  localparam logic signed [XW-1:0] HALF_PI_X = HALF_PI_A[XW-1:0];
  localparam logic signed [XW-1:0] TWO_PI_X  = TWO_PI_A[XW-1:0];

  localparam logic signed [RW-1:0] ONE_W     = RW'(64'd1 << WFRAC);
  localparam logic signed [RW-1:0] REC6_W    = RW'(64'd178956971);
  localparam logic signed [RW-1:0] REC120_W  = RW'(64'd8947849);
  localparam logic signed [BW-1:0] REC5040_W = BW'(64'd213044);

  localparam logic signed [PW-1:0] RND_HALF    = PW'(64'd1 << (WFRAC - 1));
  localparam logic signed [PW-1:0] RND_HALF_M1 = PW'((64'd1 << (WFRAC - 1)) - 64'd1);

  localparam int OW = PVW + 2;
  localparam logic signed [OW-1:0] OUT_HALF = OW'((64'd1 << OUT_SHIFT) >> 1);
  localparam logic signed [OW-1:0] OUT_ADJ  = OW'((OUT_SHIFT > 0) ? 1 : 0);
  localparam logic signed [OW-1:0] SAT_MAX  = OW'(64'h7FFF_FFFF);
  localparam logic signed [OW-1:0] SAT_MIN  = -OW'(64'h7FFF_FFFF) - OW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIR,
    S_STEP,
    S_FINAL,
    S_ABS,
    S_MUL,
    S_RND,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_SQ,
    PH_P1,
    PH_P2,
    PH_P3,
    PH_R
  } phase_t;

  typedef struct packed {
    logic              load;
    logic              dir;
    logic              step;
    logic              fin;
    logic              absval;
    logic              mul;
    logic              rnd;
    logic              out_ld;
    logic [STEP_W-1:0] step_idx;
    phase_t            phase;
  } cmd_t;

endpackage
`default_nettype wire

>>> design/sct_datapath.sv
`default_nettype none
module sct_datapath (
  input  wire logic                clk,
  input  wire sct_pkg::cmd_t       cmd,
  input  wire logic                action,
  input  wire logic signed [31:0]  angle,
  output logic signed [31:0]       value
);

  logic signed [sct_pkg::XW-1:0]  x;
  logic                           red_pos;
  logic                           red_neg;
  logic [sct_pkg::UW-1:0]         u;
  logic                           neg;
  logic [sct_pkg::X2W-1:0]        x2;
  logic signed [sct_pkg::PVW-1:0] p;
  logic signed [sct_pkg::PVW-1:0] r;
  logic signed [sct_pkg::PW-1:0]  prod;

  logic signed [sct_pkg::XW-1:0]  x_in;
  logic signed [sct_pkg::XW-1:0]  step_amt;
  logic signed [sct_pkg::XW-1:0]  cand;
  logic                           take;
  logic signed [sct_pkg::XW-1:0]  absx;
  logic signed [sct_pkg::AW-1:0]  mul_a;
  logic signed [sct_pkg::BW-1:0]  mul_b;
  logic signed [sct_pkg::PW-1:0]  rnd_full;
  logic signed [sct_pkg::RW-1:0]  rounded;
  logic signed [sct_pkg::RW-1:0]  p_calc;
  logic signed [sct_pkg::OW-1:0]  sres;
  logic signed [sct_pkg::OW-1:0]  ores;
  logic signed [31:0]             sat;

  always_comb begin
    x_in = sct_pkg::XW'(angle);
    if (action) begin
      x_in = x_in + sct_pkg::HALF_PI_X;
    end
  end

  // one binary-weighted multiple of 2*pi per step, kept only if the angle stays outside
  assign step_amt = sct_pkg::TWO_PI_X <<< cmd.step_idx;
  assign cand     = red_pos ? (x - step_amt) : (x + step_amt);
  assign take     = red_pos ? (cand > sct_pkg::PI_X) : (cand < -sct_pkg::PI_X);
  assign absx     = x[sct_pkg::XW-1] ? -x : x;

  always_comb begin
    mul_a = $signed({{(sct_pkg::AW-sct_pkg::UW){1'b0}}, u});
    mul_b = $signed({{(sct_pkg::BW-sct_pkg::UW){1'b0}}, u});
    case (cmd.phase)
      sct_pkg::PH_SQ: begin
        mul_a = $signed({{(sct_pkg::AW-sct_pkg::UW){1'b0}}, u});
        mul_b = $signed({{(sct_pkg::BW-sct_pkg::UW){1'b0}}, u});
      end
      sct_pkg::PH_P1: begin
        mul_a = $signed({{(sct_pkg::AW-sct_pkg::X2W){1'b0}}, x2});
        mul_b = sct_pkg::REC5040_W;
      end
      sct_pkg::PH_P2, sct_pkg::PH_P3: begin
        mul_a = $signed({{(sct_pkg::AW-sct_pkg::X2W){1'b0}}, x2});
        mul_b = p;
      end
      sct_pkg::PH_R: begin
        mul_a = $signed({{(sct_pkg::AW-sct_pkg::UW){1'b0}}, u});
        mul_b = p;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round to nearest, ties away from zero
  assign rnd_full = (prod + (prod[sct_pkg::PW-1] ? sct_pkg::RND_HALF_M1 : sct_pkg::RND_HALF))
                    >>> sct_pkg::WFRAC;
  assign rounded  = $signed(rnd_full[sct_pkg::RW-1:0]);

  always_comb begin
    case (cmd.phase)
      sct_pkg::PH_P1: p_calc = sct_pkg::REC120_W - rounded;
      sct_pkg::PH_P2: p_calc = sct_pkg::REC6_W - rounded;
      default:        p_calc = sct_pkg::ONE_W - rounded;
    endcase
  end

  always_comb begin
    sres = neg ? -sct_pkg::OW'(r) : sct_pkg::OW'(r);
    if (sres[sct_pkg::OW-1]) begin
      ores = (sres + sct_pkg::OUT_HALF - sct_pkg::OUT_ADJ) >>> sct_pkg::OUT_SHIFT;
    end else begin
      ores = (sres + sct_pkg::OUT_HALF) >>> sct_pkg::OUT_SHIFT;
    end
    if (ores > sct_pkg::SAT_MAX) begin
      sat = 32'sh7FFF_FFFF;
    end else if (ores < sct_pkg::SAT_MIN) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = ores[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= x_in;
    end
    if (cmd.dir) begin
      red_pos <= x > sct_pkg::PI_X;
      red_neg <= x < -sct_pkg::PI_X;
    end
    if (cmd.step && (red_pos || red_neg) && take) begin
      x <= cand;
    end
    if (cmd.fin) begin
      if (red_pos) begin
        x <= x - sct_pkg::TWO_PI_X;
      end else if (red_neg) begin
        x <= x + sct_pkg::TWO_PI_X;
      end
    end
    if (cmd.absval) begin
      neg <= x[sct_pkg::XW-1];
      u   <= sct_pkg::UW'(absx) << sct_pkg::U_SHIFT;
    end
    if (cmd.mul) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.rnd) begin
      case (cmd.phase)
        sct_pkg::PH_SQ: x2 <= rounded[sct_pkg::X2W-1:0];
        sct_pkg::PH_R:  r  <= rounded[sct_pkg::PVW-1:0];
        default:        p  <= p_calc[sct_pkg::PVW-1:0];
      endcase
    end
    if (cmd.out_ld) begin
      value <= sat;
    end
  end

endmodule
`default_nettype wire

>>> design/sct_ctrl.sv
`default_nettype none
module sct_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output sct_pkg::cmd_t     cmd
);

  sct_pkg::state_t                state;
  sct_pkg::state_t                state_next;
  logic [sct_pkg::STEP_W-1:0]     step_cnt;
  logic [sct_pkg::STEP_W-1:0]     step_cnt_next;
  sct_pkg::phase_t                phase;
  sct_pkg::phase_t                phase_next;
  logic                           out_valid_next;
  logic                           slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    phase_next    = phase;
    unique case (state)
      sct_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = sct_pkg::S_DIR;
        end
      end
      sct_pkg::S_DIR: begin
        state_next    = sct_pkg::S_STEP;
        step_cnt_next = sct_pkg::STEP_LAST;
      end
      sct_pkg::S_STEP: begin
        if (step_cnt == '0) begin
          state_next = sct_pkg::S_FINAL;
        end else begin
          step_cnt_next = step_cnt - 1'b1;
        end
      end
      sct_pkg::S_FINAL: state_next = sct_pkg::S_ABS;
      sct_pkg::S_ABS: begin
        state_next = sct_pkg::S_MUL;
        phase_next = sct_pkg::PH_SQ;
      end
      sct_pkg::S_MUL: state_next = sct_pkg::S_RND;
      sct_pkg::S_RND: begin
        if (phase == sct_pkg::PH_R) begin
          state_next = sct_pkg::S_OUT;
        end else begin
          state_next = sct_pkg::S_MUL;
          phase_next = sct_pkg::phase_t'(phase + 3'd1);
        end
      end
      sct_pkg::S_OUT: begin
        if (slot_free) begin
          state_next = sct_pkg::S_IDLE;
        end
      end
      default: state_next = sct_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.step_idx   = step_cnt;
    cmd.phase      = phase;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      sct_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sct_pkg::S_DIR:   cmd.dir    = 1'b1;
      sct_pkg::S_STEP:  cmd.step   = 1'b1;
      sct_pkg::S_FINAL: cmd.fin    = 1'b1;
      sct_pkg::S_ABS:   cmd.absval = 1'b1;
      sct_pkg::S_MUL:   cmd.mul    = 1'b1;
      sct_pkg::S_RND:   cmd.rnd    = 1'b1;
      sct_pkg::S_OUT: begin
        if (slot_free) begin
          cmd.out_ld     = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sct_pkg::S_IDLE;
      step_cnt  <= '0;
      phase     <= sct_pkg::PH_SQ;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

>>> design/sine_cosine_taylor_approx_top.sv
`default_nettype none
// Sine or cosine of a signed Q8.24 angle (action 0 sine, 1 cosine) by a seventh-order
// Taylor polynomial, returned as signed Q2.30. The angle is folded into [-pi, pi] by a
// binary search over multiples of 2*pi (one add and compare per cycle), then the
// polynomial runs in nested form on one shared 35x33 multiplier, a multiply state and a
// round state per product for five products. The input is not ready again until the
// result is loaded, so a new angle is taken only after the last one has run through
// the six reduction steps and all five products. The result sits in an output register,
// so the next angle is taken while an earlier result still waits; a second result that
// finds the register still full holds, and the input with it.
module sine_cosine_taylor_approx_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               action,
  input  wire logic signed [31:0] angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      value
);

  sct_pkg::cmd_t cmd;

  sct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sct_datapath u_datapath (
    .clk    (clk),
    .cmd    (cmd),
    .action (action),
    .angle  (angle),
    .value  (value)
  );

  localparam logic signed [31:0] VALUE_BOUND =
    32'((64'd1 << sct_pkg::RESULT_FRAC_BITS) + (64'd1 << (sct_pkg::RESULT_FRAC_BITS - 3)));

  // one transaction in flight: acceptance closes the input until the result is loaded
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // the polynomial on [-pi, pi] never leaves about one in magnitude
  a_value_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (value <= VALUE_BOUND) && (value >= -VALUE_BOUND))
    else $error("result magnitude out of range");

  // a new result is loaded only when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(value) || !out_valid)
    else $error("pending result overwritten");

endmodule
`default_nettype wire
